### rtl/core/i2c_master_bit_sequencer_assert.svh
// Assertion helpers for the I2C bit sequencer.
// Every check runs on the rising edge of clk_i and is off while rst_ni is low.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define I2CMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RECV  = 3'd3,
    CMD_SACK  = 3'd4,
    CMD_RACK  = 3'd5
  } cmd_e;

  // Phases within one bit of a byte transfer
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;

  // Last slot of each command
  localparam logic [4:0] LAST_START = 5'd3;
  localparam logic [4:0] LAST_STOP  = 5'd2;
  localparam logic [4:0] LAST_SEND  = 5'd23;
  localparam logic [4:0] LAST_RECV  = 5'd24;
  localparam logic [4:0] LAST_SACK  = 5'd2;
  localparam logic [4:0] LAST_RACK  = 5'd3;

  // Line actions for one slot
  typedef struct packed {
    logic       scl_set;
    logic       scl_val;
    logic       sda_set;
    logic       sda_val;
    logic       smp_rx;   // OR sampled SDA into the receive byte
    logic       smp_ack;  // capture sampled SDA as ack
    logic       rx_pub;   // publish the received byte
    logic       last;     // final slot of the command
    logic [7:0] bit_mask; // one-hot bit position, MSB first
  } slot_act_t;

  // Quotient by three for slot numbers 0..31, via multiply by 11 and shift
  function automatic logic [3:0] div3(input logic [4:0] s);
    logic [8:0] prod;
    prod = {1'b0, s, 3'b000} + {3'b000, s, 1'b0} + {4'b0000, s};
    return prod[8:5];
  endfunction

  // One-hot mask, MSB first
  function automatic logic [7:0] msb_mask(input logic [2:0] bit_idx);
    return 8'h80 >> bit_idx;
  endfunction

endpackage

### rtl/core/i2cms_slot_dec.sv
`timescale 1ns / 1ps

// Decodes the line action for one slot of the active command
module i2cms_slot_dec import i2cms_pkg::*; (
  input  cmd_e       cmd_i,
  input  logic [4:0] slot_i,
  input  logic [7:0] shift_i,
  input  logic       ack_drive_i,
  output slot_act_t  act_o
);

  logic [4:0] t_slot;
  logic [4:0] bit_slot;
  logic [3:0] quot;
  logic [4:0] triple;
  logic [1:0] phase;
  logic [7:0] mask;

  // Bit index and phase; receive is offset by its release slot
  assign t_slot   = slot_i - 5'd1;
  assign bit_slot = (cmd_i == CMD_RECV) ? t_slot : slot_i;
  assign quot     = div3(bit_slot);
  assign triple   = {quot, 1'b0} + {1'b0, quot};
  assign phase    = 2'(bit_slot - triple);
  assign mask     = msb_mask(quot[2:0]);

  // Per-command slot table
  always_comb begin
    act_o          = '0;
    act_o.bit_mask = mask;
    case (cmd_i)
      CMD_START: begin
        if (slot_i == 5'd0) begin
          act_o.sda_set = 1'b1;
          act_o.sda_val = 1'b1;
        end else if (slot_i == 5'd1) begin
          act_o.scl_set = 1'b1;
          act_o.scl_val = 1'b1;
        end else if (slot_i == 5'd2) begin
          act_o.sda_set = 1'b1;
        end else begin
          act_o.scl_set = 1'b1;
        end
        act_o.last = (slot_i >= LAST_START);
      end
      CMD_STOP: begin
        if (slot_i == 5'd0) begin
          act_o.sda_set = 1'b1;
        end else if (slot_i == 5'd1) begin
          act_o.scl_set = 1'b1;
          act_o.scl_val = 1'b1;
        end else begin
          act_o.sda_set = 1'b1;
          act_o.sda_val = 1'b1;
        end
        act_o.last = (slot_i >= LAST_STOP);
      end
      CMD_SEND: begin
        if (phase == PH_SETUP) begin
          act_o.sda_set = 1'b1;
          act_o.sda_val = |(shift_i & mask);
        end else if (phase == PH_HIGH) begin
          act_o.scl_set = 1'b1;
          act_o.scl_val = 1'b1;
        end else begin
          act_o.scl_set = 1'b1;
        end
        act_o.last = (slot_i >= LAST_SEND);
      end
      CMD_RECV: begin
        if (slot_i == 5'd0) begin
          act_o.sda_set = 1'b1;
          act_o.sda_val = 1'b1;
        end else if (phase == PH_SETUP) begin
          act_o.scl_set = 1'b1;
          act_o.scl_val = 1'b1;
        end else if (phase == PH_HIGH) begin
          act_o.smp_rx = 1'b1;
        end else begin
          act_o.scl_set = 1'b1;
        end
        act_o.last   = (slot_i >= LAST_RECV);
        act_o.rx_pub = (slot_i >= LAST_RECV);
      end
      CMD_SACK: begin
        if (slot_i == 5'd0) begin
          act_o.sda_set = 1'b1;
          act_o.sda_val = ack_drive_i;
        end else if (slot_i == 5'd1) begin
          act_o.scl_set = 1'b1;
          act_o.scl_val = 1'b1;
        end else begin
          act_o.scl_set = 1'b1;
        end
        act_o.last = (slot_i >= LAST_SACK);
      end
      default: begin
        // receive ack: release SDA, raise SCL, sample, drop SCL
        if (slot_i == 5'd0) begin
          act_o.sda_set = 1'b1;
          act_o.sda_val = 1'b1;
        end else if (slot_i == 5'd1) begin
          act_o.scl_set = 1'b1;
          act_o.scl_val = 1'b1;
        end else if (slot_i == 5'd2) begin
          act_o.smp_ack = 1'b1;
        end else begin
          act_o.scl_set = 1'b1;
        end
        act_o.last = (slot_i >= LAST_RACK);
      end
    endcase
  end

endmodule

### rtl/core/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps

// I2C master line sequencer. Each accepted word is one slot tick from an
// external timer; a tick that finds the block idle with cmd_valid_i set
// starts a command (start, stop, send byte, receive byte, send ack, receive
// ack) and runs its first slot at once. Every accepted word yields exactly
// one result word, registered, on the cycle after acceptance: the SCL and
// SDA levels after the slot, busy, done on the final slot, and the latest
// received byte and ack. One word is taken per clock; in_ready_o is high
// whenever the result register is empty or is being emptied in the same
// cycle, so throughput is set only by the output side. Commands arriving
// while busy, and unknown command codes, are dropped.
module i2c_master_bit_sequencer import i2cms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_valid_i,
  input  logic [2:0] req_type_i,
  input  logic [7:0] tx_byte_i,
  input  logic       ack_bit_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_in_o
);

`include "i2c_master_bit_sequencer_assert.svh"

  cmd_e       cmd_q, cmd_d, cmd_eff;
  logic [4:0] slot_q, slot_d, slot_eff;
  logic [7:0] shift_q, shift_d, shift_eff;
  logic       ack_drv_q, ack_drv_d, ack_drv_eff;
  logic       running_q, running_d;
  logic       scl_q, scl_d, sda_q, sda_d;
  logic [7:0] rx_q, rx_d;
  logic       ack_q, ack_d;
  logic       done_q, done_d;
  logic       out_valid_q;
  logic       accept;
  logic       req_ok;
  logic       launch;
  logic       active;
  slot_act_t  act;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Command launch: only from idle and only for a known code
  assign req_ok      = (req_type_i <= 3'(CMD_RACK));
  assign launch      = !running_q && cmd_valid_i && req_ok;
  assign active      = running_q || launch;
  assign cmd_eff     = launch ? cmd_e'(req_type_i) : cmd_q;
  assign slot_eff    = launch ? 5'd0 : slot_q;
  assign shift_eff   = launch ? ((req_type_i == 3'(CMD_SEND)) ? tx_byte_i : 8'h00) : shift_q;
  assign ack_drv_eff = launch ? ack_bit_i : ack_drv_q;

  i2cms_slot_dec u_slot_dec (
    .cmd_i       (cmd_eff),
    .slot_i      (slot_eff),
    .shift_i     (shift_eff),
    .ack_drive_i (ack_drv_eff),
    .act_o       (act)
  );

  // Next state for one slot
  always_comb begin
    cmd_d     = cmd_eff;
    ack_drv_d = ack_drv_eff;
    shift_d   = shift_eff;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rx_d      = rx_q;
    ack_d     = ack_q;
    done_d    = 1'b0;
    running_d = running_q;
    slot_d    = slot_q;
    if (active) begin
      if (act.scl_set) begin
        scl_d = act.scl_val;
      end
      if (act.sda_set) begin
        sda_d = act.sda_val;
      end
      if (act.smp_rx && sda_in_i) begin
        shift_d = shift_eff | act.bit_mask;
      end
      if (act.smp_ack) begin
        ack_d = sda_in_i;
      end
      if (act.rx_pub) begin
        rx_d = shift_d;
      end
      done_d    = act.last;
      running_d = !act.last;
      slot_d    = act.last ? 5'd0 : (slot_eff + 5'd1);
    end
  end

  // Sequencer state; line levels double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= CMD_START;
      slot_q    <= 5'd0;
      shift_q   <= 8'h00;
      ack_drv_q <= 1'b0;
      running_q <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      rx_q      <= 8'h00;
      ack_q     <= 1'b0;
      done_q    <= 1'b0;
    end else if (accept) begin
      cmd_q     <= cmd_d;
      slot_q    <= slot_d;
      shift_q   <= shift_d;
      ack_drv_q <= ack_drv_d;
      running_q <= running_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      rx_q      <= rx_d;
      ack_q     <= ack_d;
      done_q    <= done_d;
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = scl_q;
  assign sda_out_o   = sda_q;
  assign busy_res_o  = running_q;
  assign done_res_o  = done_q;
  assign rx_byte_o   = rx_q;
  assign ack_in_o    = ack_q;

  // Checks
  `I2CMS_ASSERT_NOW(a_done_not_busy, done_q, !running_q, "done and busy together")
  `I2CMS_ASSERT_NOW(a_slot_range, 1'b1, slot_q <= LAST_RECV, "slot counter out of range")
  `I2CMS_ASSERT_NOW(a_idle_slot_zero, !running_q, slot_q == 5'd0, "idle with slot not zero")
  `I2CMS_ASSERT_NEXT(a_bad_code, accept && !running_q && !req_ok, !running_q, "unknown code started")

endmodule
